// File: rtl/core/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

   // Queue depth and derived widths
   localparam int CAPACITY = 64;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL_DROP = 2'd1,
      ST_EMPTY_REM = 2'd2
   } status_type;

   // One request transaction
   typedef struct packed {
      opcode_type                 opcode;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   // One response transaction
   typedef struct packed {
      logic signed [VALUE_W-1:0]  removed_value;
      logic signed [VALUE_W-1:0]  top_value;
      logic [COUNT_W-1:0]         entry_count;
      logic                       is_empty;
      status_type                 status;
   } rsp_type;

   // Broadcast control to every cell
   typedef struct packed {
      logic                       insert;
      logic                       remove;
      logic signed [VALUE_W-1:0]  new_value;
      logic [COUNT_W-1:0]         count;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/max_heap_priority_queue_top.sv
// Max priority queue of signed 32-bit values, kept as a sorted chain of cells.
// The response strobe comes in the cycle after the start transaction.
// Throughput: 1 transaction per cycle; busy stays low, since every cell
// shifts or loads in parallel on each update.
// Reset: synchronous, active high; clears the fill count and the strobe.
// The receiver cannot stall: each response is shown for exactly one cycle.
`default_nettype none

module max_heap_priority_queue_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire mhpq_pkg::req_type  req_data,
   output logic                    rsp_valid,
   output mhpq_pkg::rsp_type       rsp_data
);

   localparam int N = mhpq_pkg::CAPACITY;

   logic [mhpq_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                                valid_ff;
   logic signed [mhpq_pkg::VALUE_W-1:0] removed_ff, removed_in;
   mhpq_pkg::status_type                status_ff, status_in;
   mhpq_pkg::cell_ctrl_type             ctrl;
   logic                                accept;
   logic                                is_full, is_void;

   logic                                cell_gt    [N];
   logic signed [mhpq_pkg::VALUE_W-1:0] cell_value [N];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign is_full = count_ff == mhpq_pkg::COUNT_W'(N);
   assign is_void = count_ff == '0;

   // Decode the transaction into cell control, next count, status and removed value
   always_comb begin
      ctrl.insert    = 1'b0;
      ctrl.remove    = 1'b0;
      ctrl.new_value = req_data.value;
      ctrl.count     = count_ff;
      count_in       = count_ff;
      removed_in     = '0;
      status_in      = mhpq_pkg::ST_OK;
      if (accept) begin
         unique case (req_data.opcode)
            mhpq_pkg::OP_INSERT: begin
               if (is_full) begin
                  status_in = mhpq_pkg::ST_FULL_DROP;
               end else begin
                  ctrl.insert = 1'b1;
                  count_in    = count_ff + mhpq_pkg::COUNT_W'(1);
               end
            end
            mhpq_pkg::OP_REMOVE: begin
               if (is_void) begin
                  status_in = mhpq_pkg::ST_EMPTY_REM;
               end else begin
                  ctrl.remove = 1'b1;
                  removed_in  = cell_value[0];
                  count_in    = count_ff - mhpq_pkg::COUNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // Cell chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                                l_gt;
      logic signed [mhpq_pkg::VALUE_W-1:0] l_val, r_val;
      if (i == 0) begin : g_head
         assign l_gt  = 1'b0;
         assign l_val = '0;
      end else begin : g_mid
         assign l_gt  = cell_gt[i-1];
         assign l_val = cell_value[i-1];
      end
      if (i == N - 1) begin : g_tail
         assign r_val = '0;
      end else begin : g_body
         assign r_val = cell_value[i+1];
      end
      mhpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .slot_idx    (mhpq_pkg::COUNT_W'(i)),
         .left_gt     (l_gt),
         .left_value  (l_val),
         .right_value (r_val),
         .gt          (cell_gt[i]),
         .value       (cell_value[i])
      );
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= accept;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_data.removed_value = removed_ff;
   assign rsp_data.top_value     = is_void ? '0 : cell_value[0];
   assign rsp_data.entry_count   = count_ff;
   assign rsp_data.is_empty      = is_void;
   assign rsp_data.status        = status_ff;

endmodule

`default_nettype wire

// File: rtl/core/mhpq_cell.sv
`default_nettype none

// One slot of the sorted chain. Slot 0 holds the largest value.
module mhpq_cell (
   input  wire logic                                   clock,
   input  wire mhpq_pkg::cell_ctrl_type                ctrl,
   input  wire logic [mhpq_pkg::COUNT_W-1:0]           slot_idx,
   input  wire logic                                   left_gt,
   input  wire logic signed [mhpq_pkg::VALUE_W-1:0]    left_value,
   input  wire logic signed [mhpq_pkg::VALUE_W-1:0]    right_value,
   output logic                                        gt,
   output logic signed [mhpq_pkg::VALUE_W-1:0]         value
);

   logic signed [mhpq_pkg::VALUE_W-1:0] value_ff;
   logic signed [mhpq_pkg::VALUE_W-1:0] value_in;
   logic                                occupied;

   // Slot holds data when below the fill count
   assign occupied = slot_idx < ctrl.count;

   // New value belongs in front of this slot (empty slots rank lowest)
   assign gt = !occupied || (ctrl.new_value > value_ff);

   // Insert: first slot with gt takes the new value, later ones shift right.
   // Remove: everything shifts left by one.
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (gt) begin
            value_in = left_gt ? left_value : ctrl.new_value;
         end
      end else if (ctrl.remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// File: rtl/core/mhpq_checker.sv
`default_nettype none

module mhpq_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire mhpq_pkg::req_type  req_data,
   input wire logic               rsp_valid,
   input wire mhpq_pkg::rsp_type  rsp_data
);

   // One response per accepted transaction, in the following cycle
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy && !reset))
      else $error("response strobe does not follow the request");

   // Empty flag and top value agree with the count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == '0)) &&
                    (!rsp_data.is_empty || rsp_data.top_value == '0))
      else $error("empty flag inconsistent");

   // A dropped insert only happens at full capacity
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == mhpq_pkg::ST_FULL_DROP) |->
         rsp_data.entry_count == mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY))
      else $error("insert dropped below capacity");

   // Removed value is never below the new maximum
   a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == mhpq_pkg::ST_OK &&
       $past(req_data.opcode) == mhpq_pkg::OP_REMOVE && !rsp_data.is_empty) |->
         rsp_data.removed_value >= rsp_data.top_value)
      else $error("removed value below remaining maximum");

endmodule

bind max_heap_priority_queue_top mhpq_checker u_mhpq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
